### design/bps_pkg.sv
// ----------------------------------------------------------------------------
// Blinn-Phong shade package
// Shared widths, payload structs, register codes and the log2/exp2 tables.
// ----------------------------------------------------------------------------
package bps_pkg;

	localparam int POW_TABLE_ADDR_BITS = 10;
	localparam int TAB_DEPTH = 1 << POW_TABLE_ADDR_BITS;

	localparam int NUM_W  = 43;   // dot << 10
	localparam int RAD_W  = 54;   // |s|^2 << 20
	localparam int ROOT_W = 27;   // sqrt of RAD
	localparam int Q_W    = 14;   // cosine quotient bits below 1.0
	localparam int H_W    = 15;   // cosine incl. saturated 1.0
	localparam int F_W    = 15;   // specular factor, Q.14

	localparam logic [H_W-1:0] ONE_Q14 = H_W'(16384);
	localparam logic [16:0]    OUT_MAX = 17'h1FFFF;

	localparam logic [1:0] CFG_SPEC_RED   = 2'd0;
	localparam logic [1:0] CFG_SPEC_GREEN = 2'd1;
	localparam logic [1:0] CFG_SPEC_BLUE  = 2'd2;
	localparam logic [1:0] CFG_SHININESS  = 2'd3;

	typedef struct packed {
		logic [47:0] diffuse;
		logic        front;
	} side_t;

	typedef struct packed {
		side_t              side;
		logic               active;
		logic [NUM_W-1:0]   num;
		logic [ROOT_W-1:0]  root;
	} geo_t;

	typedef struct packed {
		side_t          side;
		logic [H_W-1:0] h;
	} hcos_t;

	typedef struct packed {
		side_t          side;
		logic [F_W-1:0] f;
	} powr_t;

	typedef logic [TAB_DEPTH-1:0][15:0] log_tab_t;
	typedef logic [TAB_DEPTH-1:0][30:0] exp_tab_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] rem;
		logic [63:0] res;
		logic [63:0] bitv;
		rem  = v;
		res  = '0;
		bitv = 64'd1 << 62;
		while (bitv > rem)
			bitv = bitv >> 2;
		while (bitv != 64'd0) begin
			if (rem >= res + bitv) begin
				rem = rem - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// log2(1 + i/2^A) in Q0.16 by repeated squaring
	function automatic log_tab_t gen_log_tab();
		log_tab_t    tab;
		logic [63:0] x;
		logic [15:0] frac;
		for (int i = 0; i < TAB_DEPTH; i++) begin
			x    = (64'd1 << 30) + (64'(i) << (30 - POW_TABLE_ADDR_BITS));
			frac = '0;
			for (int k = 0; k < 16; k++) begin
				x    = (x * x) >> 30;
				frac = frac << 1;
				if (x >= (64'd2 << 30)) begin
					x       = x >> 1;
					frac[0] = 1'b1;
				end
			end
			tab[i] = frac;
		end
		return tab;
	endfunction

	// 2^(-j/2^A) in Q.30 as a product of 2^(-2^-k) factors
	function automatic exp_tab_t gen_exp_tab();
		exp_tab_t    tab;
		logic [63:0] c [POW_TABLE_ADDR_BITS];
		logic [63:0] e;
		c[0] = isqrt64(64'd1 << 59);
		for (int k = 1; k < POW_TABLE_ADDR_BITS; k++)
			c[k] = isqrt64(c[k-1] << 30);
		for (int j = 0; j < TAB_DEPTH; j++) begin
			e = 64'd1 << 30;
			for (int k = 1; k <= POW_TABLE_ADDR_BITS; k++) begin
				if (((j >> (POW_TABLE_ADDR_BITS - k)) & 1) != 0)
					e = (e * c[k-1]) >> 30;
			end
			tab[j] = e[30:0];
		end
		return tab;
	endfunction

	localparam log_tab_t LOG_TAB = gen_log_tab();
	localparam exp_tab_t EXP_TAB = gen_exp_tab();

endpackage

### design/bps_hit_if.sv
// ----------------------------------------------------------------------------
// Hit channel
// Valid/ready stream carrying one ray hit to be shaded.
// ----------------------------------------------------------------------------
interface bps_hit_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] normal_x;
	logic signed [15:0] normal_y;
	logic signed [15:0] normal_z;
	logic signed [15:0] light_x;
	logic signed [15:0] light_y;
	logic signed [15:0] light_z;
	logic signed [15:0] view_x;
	logic signed [15:0] view_y;
	logic signed [15:0] view_z;
	logic [47:0]        diffuse_rgb;
	logic               front_face;

	modport source (
		output valid, normal_x, normal_y, normal_z, light_x, light_y, light_z,
		output view_x, view_y, view_z, diffuse_rgb, front_face,
		input  ready
	);
	modport sink (
		input  valid, normal_x, normal_y, normal_z, light_x, light_y, light_z,
		input  view_x, view_y, view_z, diffuse_rgb, front_face,
		output ready
	);
endinterface

### design/bps_color_if.sv
// ----------------------------------------------------------------------------
// Color channel
// Valid/ready stream carrying one shaded color.
// ----------------------------------------------------------------------------
interface bps_color_if;
	logic        valid;
	logic        ready;
	logic [16:0] out_red;
	logic [16:0] out_green;
	logic [16:0] out_blue;

	modport source (output valid, out_red, out_green, out_blue, input ready);
	modport sink (input valid, out_red, out_green, out_blue, output ready);
endinterface

### design/blinn_phong_shade_unit.sv
// ----------------------------------------------------------------------------
// Blinn-Phong shade unit
// Diffuse plus specular color of one ray hit per cycle while not stalled.
// ----------------------------------------------------------------------------
// One hit enters per clock while the pipeline has room. The stages are 3 of
// vector math, 27 of square root (one root bit each), 15 of cosine division
// (a saturation check, then one quotient bit each), 5 of log2/exp2 power and
// 2 of color scale and add. The pipeline holds up to 52 hits; bubbles close
// up on a stall, so input keeps flowing until every stage is full.
// Write the specular color and shininess only while no hit is in flight.
// ----------------------------------------------------------------------------
module blinn_phong_shade_unit (
	input  logic        clk,
	input  logic        arst_n,
	bps_hit_if.sink     hit,
	bps_color_if.source color,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic [15:0] spec_red_q, spec_green_q, spec_blue_q, shininess_q;

	logic           geo_valid, geo_ready;
	bps_pkg::geo_t  geo;
	logic           cos_valid, cos_ready;
	bps_pkg::hcos_t cosv;
	logic           pow_valid, pow_ready;
	bps_pkg::powr_t powv;

	logic           v_s1, v_s2, rdy_s1, rdy_s2;
	bps_pkg::side_t side_s1;
	logic [16:0]    sr_s1, sg_s1, sb_s1;
	logic [16:0]    red_s2, green_s2, blue_s2;
	logic           front_s2;
	logic [30:0]    pr, pg, pb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spec_red_q   <= '0;
			spec_green_q <= '0;
			spec_blue_q  <= '0;
			shininess_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bps_pkg::CFG_SPEC_RED:   spec_red_q   <= cfg_data;
				bps_pkg::CFG_SPEC_GREEN: spec_green_q <= cfg_data;
				bps_pkg::CFG_SPEC_BLUE:  spec_blue_q  <= cfg_data;
				bps_pkg::CFG_SHININESS:  shininess_q  <= cfg_data;
			endcase
		end
	end

	bps_geom u_geom (
		.clk       (clk),
		.arst_n    (arst_n),
		.hit       (hit),
		.out_valid (geo_valid),
		.out_ready (geo_ready),
		.out_geo   (geo)
	);

	bps_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (geo_valid),
		.in_ready  (geo_ready),
		.in_geo    (geo),
		.out_valid (cos_valid),
		.out_ready (cos_ready),
		.out_cos   (cosv)
	);

	bps_pow u_pow (
		.clk       (clk),
		.arst_n    (arst_n),
		.shininess (shininess_q),
		.in_valid  (cos_valid),
		.in_ready  (cos_ready),
		.in_cos    (cosv),
		.out_valid (pow_valid),
		.out_ready (pow_ready),
		.out_pow   (powv)
	);

	assign rdy_s2    = !v_s2 || color.ready;
	assign rdy_s1    = !v_s1 || rdy_s2;
	assign pow_ready = rdy_s1;

	always_comb begin
		pr = spec_red_q   * powv.f;
		pg = spec_green_q * powv.f;
		pb = spec_blue_q  * powv.f;
	end

	function automatic logic [16:0] sat_add(input logic [15:0] a, input logic [16:0] b);
		logic [17:0] s;
		s = 18'(a) + 18'(b);
		return (s > 18'(bps_pkg::OUT_MAX)) ? bps_pkg::OUT_MAX : s[16:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= pow_valid;
			if (rdy_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			side_s1 <= powv.side;
			sr_s1   <= pr[30:14];
			sg_s1   <= pg[30:14];
			sb_s1   <= pb[30:14];
		end
		if (rdy_s2) begin
			front_s2 <= side_s1.front;
			// back face: flat yellow, diffuse and specular dropped
			if (!side_s1.front) begin
				red_s2   <= 17'(bps_pkg::ONE_Q14);
				green_s2 <= 17'(bps_pkg::ONE_Q14);
				blue_s2  <= '0;
			end else begin
				red_s2   <= sat_add(side_s1.diffuse[47:32], sr_s1);
				green_s2 <= sat_add(side_s1.diffuse[31:16], sg_s1);
				blue_s2  <= sat_add(side_s1.diffuse[15:0],  sb_s1);
			end
		end
	end

	assign color.valid     = v_s2;
	assign color.out_red   = red_s2;
	assign color.out_green = green_s2;
	assign color.out_blue  = blue_s2;

	a_back_yellow: assert property (@(posedge clk) disable iff (!arst_n)
		(color.valid && !front_s2) |->
		(color.out_red == 17'(bps_pkg::ONE_Q14) && color.out_green == 17'(bps_pkg::ONE_Q14)
		 && color.out_blue == 17'd0))
		else $error("back face not yellow");

endmodule

### design/bps_geom.sv
// ----------------------------------------------------------------------------
// Blinn-Phong geometry front end
// Halfway sum, dot and squared length, then a bit-per-stage square root.
// ----------------------------------------------------------------------------
module bps_geom (
	input  logic           clk,
	input  logic           arst_n,
	bps_hit_if.sink        hit,
	output logic           out_valid,
	input  logic           out_ready,
	output bps_pkg::geo_t  out_geo
);

	typedef struct packed {
		bps_pkg::side_t                 side;
		logic                           active;
		logic [bps_pkg::NUM_W-1:0]      num;
		logic [bps_pkg::RAD_W-1:0]      rem;
		logic [bps_pkg::ROOT_W-1:0]     root;
	} sqrt_t;

	localparam int NS = bps_pkg::ROOT_W;

	logic               v_s1, v_s2, v_s3;
	logic               rdy_s1, rdy_s2, rdy_s3;
	logic signed [15:0] nx_s1, ny_s1, nz_s1;
	logic signed [16:0] sx_s1, sy_s1, sz_s1;
	bps_pkg::side_t     side_s1, side_s2;
	logic signed [32:0] px_s2, py_s2, pz_s2;
	logic signed [33:0] qx_s2, qy_s2, qz_s2;
	sqrt_t              sq_s3;
	logic signed [34:0] dsum;
	logic [33:0]        sqsum;

	logic [NS-1:0]      sqv_s;
	logic [NS:0]        sq_rdy;
	sqrt_t              sqd_s [NS];
	sqrt_t              sq_in [NS];
	sqrt_t              sq_nxt [NS];

	assign rdy_s1   = !v_s1 || rdy_s2;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s3   = !v_s3 || sq_rdy[0];
	assign hit.ready = rdy_s1;

	assign sq_rdy[NS] = out_ready;
	for (genvar k = 0; k < NS; k++) begin : g_rdy
		assign sq_rdy[k] = !sqv_s[k] || sq_rdy[k+1];
	end

	always_comb begin
		dsum  = 35'(px_s2) + 35'(py_s2) + 35'(pz_s2);
		sqsum = 34'(qx_s2[32:0]) + 34'(qy_s2[32:0]) + 34'(qz_s2[32:0]);
	end

	// one root bit per stage, most significant first
	always_comb begin
		logic [55:0] trial;
		trial = '0;
		sq_in[0] = sq_s3;
		for (int k = 1; k < NS; k++)
			sq_in[k] = sqd_s[k-1];
		for (int k = 0; k < NS; k++) begin
			sq_nxt[k] = sq_in[k];
			trial = (56'(sq_in[k].root) << (NS - k)) + (56'd1 << (2 * (NS - 1 - k)));
			if (56'(sq_in[k].rem) >= trial) begin
				sq_nxt[k].rem = sq_in[k].rem - trial[bps_pkg::RAD_W-1:0];
				sq_nxt[k].root[NS-1-k] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			sqv_s <= '0;
		end else begin
			if (rdy_s1) v_s1 <= hit.valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			for (int k = 0; k < NS; k++) begin
				if (sq_rdy[k])
					sqv_s[k] <= (k == 0) ? v_s3 : sqv_s[(k == 0) ? 0 : k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			nx_s1 <= hit.normal_x;
			ny_s1 <= hit.normal_y;
			nz_s1 <= hit.normal_z;
			sx_s1 <= 17'(hit.light_x) + 17'(hit.view_x);
			sy_s1 <= 17'(hit.light_y) + 17'(hit.view_y);
			sz_s1 <= 17'(hit.light_z) + 17'(hit.view_z);
			side_s1.diffuse <= hit.diffuse_rgb;
			side_s1.front   <= hit.front_face;
		end
		if (rdy_s2) begin
			px_s2   <= nx_s1 * sx_s1;
			py_s2   <= ny_s1 * sy_s1;
			pz_s2   <= nz_s1 * sz_s1;
			qx_s2   <= sx_s1 * sx_s1;
			qy_s2   <= sy_s1 * sy_s1;
			qz_s2   <= sz_s1 * sz_s1;
			side_s2 <= side_s1;
		end
		if (rdy_s3) begin
			sq_s3.side   <= side_s2;
			sq_s3.active <= side_s2.front && (sqsum != 34'd0) && (dsum > 35'sd0);
			sq_s3.num    <= {dsum[32:0], 10'd0};
			sq_s3.rem    <= {sqsum, 20'd0};
			sq_s3.root   <= '0;
		end
		for (int k = 0; k < NS; k++) begin
			if (sq_rdy[k])
				sqd_s[k] <= sq_nxt[k];
		end
	end

	assign out_valid      = sqv_s[NS-1];
	assign out_geo.side   = sqd_s[NS-1].side;
	assign out_geo.active = sqd_s[NS-1].active;
	assign out_geo.num    = sqd_s[NS-1].num;
	assign out_geo.root   = sqd_s[NS-1].root;

endmodule

### design/bps_div.sv
// ----------------------------------------------------------------------------
// Blinn-Phong cosine divider
// Saturating restoring division of the dot by the length, one bit per stage.
// ----------------------------------------------------------------------------
module bps_div (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  bps_pkg::geo_t  in_geo,
	output logic           out_valid,
	input  logic           out_ready,
	output bps_pkg::hcos_t out_cos
);

	typedef struct packed {
		bps_pkg::side_t             side;
		logic                       active;
		logic                       sat;
		logic [bps_pkg::NUM_W-1:0]  rem;
		logic [bps_pkg::ROOT_W-1:0] root;
		logic [bps_pkg::Q_W-1:0]    q;
	} div_t;

	localparam int NS = bps_pkg::Q_W + 1;

	logic [NS-1:0] dv_s;
	logic [NS:0]   d_rdy;
	div_t          dd_s  [NS];
	div_t          d_in  [NS];
	div_t          d_nxt [NS];

	assign d_rdy[NS] = out_ready;
	for (genvar k = 0; k < NS; k++) begin : g_rdy
		assign d_rdy[k] = !dv_s[k] || d_rdy[k+1];
	end
	assign in_ready = d_rdy[0];

	always_comb begin
		logic [bps_pkg::NUM_W-1:0] dvs;
		dvs = '0;
		d_in[0].side   = in_geo.side;
		d_in[0].active = in_geo.active;
		d_in[0].sat    = 1'b0;
		d_in[0].rem    = in_geo.num;
		d_in[0].root   = in_geo.root;
		d_in[0].q      = '0;
		for (int k = 1; k < NS; k++)
			d_in[k] = dd_s[k-1];
		// first stage: quotient of 1.0 or more saturates
		d_nxt[0]     = d_in[0];
		d_nxt[0].sat = in_geo.num >= (bps_pkg::NUM_W'(in_geo.root) << bps_pkg::Q_W);
		for (int k = 1; k < NS; k++) begin
			d_nxt[k] = d_in[k];
			dvs = bps_pkg::NUM_W'(d_in[k].root) << (NS - 1 - k);
			if (d_in[k].rem >= dvs) begin
				d_nxt[k].rem = d_in[k].rem - dvs;
				d_nxt[k].q[NS-1-k] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_s <= '0;
		end else begin
			for (int k = 0; k < NS; k++) begin
				if (d_rdy[k])
					dv_s[k] <= (k == 0) ? in_valid : dv_s[(k == 0) ? 0 : k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < NS; k++) begin
			if (d_rdy[k])
				dd_s[k] <= d_nxt[k];
		end
	end

	assign out_valid    = dv_s[NS-1];
	assign out_cos.side = dd_s[NS-1].side;
	assign out_cos.h    = !dd_s[NS-1].active ? '0 :
	                      dd_s[NS-1].sat     ? bps_pkg::ONE_Q14 :
	                      bps_pkg::H_W'(dd_s[NS-1].q);

	a_cos_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_cos.h <= bps_pkg::ONE_Q14)
		else $error("cosine above one");
	a_cos_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !dd_s[NS-1].active) |-> out_cos.h == '0)
		else $error("inactive hit with nonzero cosine");

endmodule

### design/bps_pow.sv
// ----------------------------------------------------------------------------
// Blinn-Phong specular power
// cos^shininess through a log2 table, one multiply and an exp2 table.
// ----------------------------------------------------------------------------
module bps_pow (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [15:0]    shininess,
	input  logic           in_valid,
	output logic           in_ready,
	input  bps_pkg::hcos_t in_cos,
	output logic           out_valid,
	input  logic           out_ready,
	output bps_pkg::powr_t out_pow
);

	localparam int A = bps_pkg::POW_TABLE_ADDR_BITS;

	localparam logic [1:0] MODE_NORM = 2'd0;
	localparam logic [1:0] MODE_ONE  = 2'd1;
	localparam logic [1:0] MODE_ZERO = 2'd2;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5;

	bps_pkg::side_t side_s1, side_s2, side_s3, side_s4, side_s5;
	logic [1:0]     mode_s1, mode_s2, mode_s3, mode_s4;
	logic [A-1:0]   idx_s1;
	logic [3:0]     p_s1, p_s2;
	logic [15:0]    log_s2;
	logic [27:0]    y_s3;
	logic [30:0]    exp_s4;
	logic [3:0]     q_s4;
	logic           qbig_s4;
	logic [bps_pkg::F_W-1:0] f_s5;

	logic [3:0]      p_c;
	logic [13:0]     hn;
	logic [12+A:0]   mant;
	logic [1:0]      mode_c;
	logic [19:0]     nl;
	logic [35:0]     prod;
	logic [30:0]     shifted;
	logic [bps_pkg::F_W-1:0] f_c;

	assign rdy_s5   = !v_s5 || out_ready;
	assign rdy_s4   = !v_s4 || rdy_s5;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	// normalize the cosine and pick the log index
	always_comb begin
		p_c = '0;
		for (int b = 0; b < 14; b++) begin
			if (in_cos.h[b])
				p_c = 4'(b);
		end
		hn   = in_cos.h[13:0] << (4'd13 - p_c);
		mant = {hn[12:0], {A{1'b0}}};
		if (shininess == 16'd0)
			mode_c = MODE_ONE;
		else if (in_cos.h == '0)
			mode_c = MODE_ZERO;
		else if (in_cos.h[14])
			mode_c = MODE_ONE;
		else
			mode_c = MODE_NORM;
	end

	always_comb begin
		nl   = {4'd14 - p_s2, 16'd0} - {4'd0, log_s2};
		prod = nl * shininess;
	end

	always_comb begin
		shifted = exp_s4 >> (5'd16 + {1'b0, q_s4});
		case (mode_s4)
			MODE_ONE:  f_c = bps_pkg::ONE_Q14;
			MODE_ZERO: f_c = '0;
			default:   f_c = qbig_s4 ? '0 : shifted[bps_pkg::F_W-1:0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			side_s1 <= in_cos.side;
			mode_s1 <= mode_c;
			idx_s1  <= mant[12+A -: A];
			p_s1    <= p_c;
		end
		if (rdy_s2) begin
			side_s2 <= side_s1;
			mode_s2 <= mode_s1;
			p_s2    <= p_s1;
			log_s2  <= bps_pkg::LOG_TAB[idx_s1];
		end
		if (rdy_s3) begin
			side_s3 <= side_s2;
			mode_s3 <= mode_s2;
			y_s3    <= prod[35:8];
		end
		if (rdy_s4) begin
			side_s4 <= side_s3;
			mode_s4 <= mode_s3;
			exp_s4  <= bps_pkg::EXP_TAB[y_s3[15 -: A]];
			q_s4    <= y_s3[19:16];
			qbig_s4 <= y_s3[27:16] > 12'd14;
		end
		if (rdy_s5) begin
			side_s5 <= side_s4;
			f_s5    <= f_c;
		end
	end

	assign out_valid    = v_s5;
	assign out_pow.side = side_s5;
	assign out_pow.f    = f_s5;

	a_zero_exp: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && shininess == 16'd0) |-> f_s5 == bps_pkg::ONE_Q14)
		else $error("zero shininess must give one");

endmodule

### sim/bps_shade_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Blinn-Phong shade checker
// Watches the hit and color channels, predicts each shaded color from the
// accepted hit and the register shadow, and compares in order.
// ----------------------------------------------------------------------------
module bps_shade_checker (
	input  logic        clk,
	input  logic        arst_n,
	bps_hit_if          hit,
	bps_color_if        color,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          errors,
	output int          pending,
	output int          colors_seen
);

	typedef struct packed {
		logic [16:0] red;
		logic [16:0] green;
		logic [16:0] blue;
	} rgb_t;

	logic [15:0] spec_r, spec_g, spec_b, shine;
	rgb_t        color_q [$];
	logic [15:0] log_lut [bps_pkg::TAB_DEPTH];
	logic [63:0] exp_lut [bps_pkg::TAB_DEPTH];

	function automatic logic [63:0] root64(input logic [63:0] v);
		logic [63:0] rem, res, b;
		rem = v;
		res = 0;
		b   = 64'd1 << 62;
		while (b > rem)
			b = b >> 2;
		while (b != 0) begin
			if (rem >= res + b) begin
				rem = rem - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	initial begin
		logic [63:0] x, c, e;
		logic [15:0] fr;
		for (int i = 0; i < bps_pkg::TAB_DEPTH; i++) begin
			x  = (64'd1 << 30) + (64'(i) << (30 - bps_pkg::POW_TABLE_ADDR_BITS));
			fr = 0;
			for (int k = 0; k < 16; k++) begin
				x  = (x * x) >> 30;
				fr = fr << 1;
				if (x >= (64'd2 << 30)) begin
					x     = x >> 1;
					fr[0] = 1'b1;
				end
			end
			log_lut[i] = fr;
			c = root64(64'd1 << 59);
			e = 64'd1 << 30;
			for (int k = 1; k <= bps_pkg::POW_TABLE_ADDR_BITS; k++) begin
				if ((i >> (bps_pkg::POW_TABLE_ADDR_BITS - k)) & 1)
					e = (e * c) >> 30;
				c = root64(c << 30);
			end
			exp_lut[i] = e;
		end
	end

	// specular factor in Q.14 for cosine h and the current shininess
	function automatic logic [63:0] spec_power(input logic [63:0] h);
		int          p;
		logic [63:0] mb, idx, nl, y, q, j;
		if (shine == 0) return 64'd16384;
		if (h == 0) return 0;
		if (h >= 16384) return 64'd16384;
		p = 13;
		while (h[p] == 1'b0)
			p--;
		mb  = h - (64'd1 << p);
		idx = (p >= bps_pkg::POW_TABLE_ADDR_BITS)
		      ? mb >> (p - bps_pkg::POW_TABLE_ADDR_BITS)
		      : mb << (bps_pkg::POW_TABLE_ADDR_BITS - p);
		nl  = 64'(14 - p) * 65536 - log_lut[idx];
		y   = (nl * shine) >> 8;
		q   = y >> 16;
		j   = (y & 64'hFFFF) >> (16 - bps_pkg::POW_TABLE_ADDR_BITS);
		if (16 + q > 62) return 0;
		return exp_lut[j] >> (16 + q);
	endfunction

	function automatic rgb_t shade_hit();
		rgb_t                res;
		logic signed [63:0]  n [3], s [3];
		logic signed [63:0]  d;
		logic [63:0]         sq, h, f, v, r;
		logic [15:0]         dif [3], sp [3];
		if (!hit.front_face) begin
			res.red   = 17'd16384;
			res.green = 17'd16384;
			res.blue  = 17'd0;
			return res;
		end
		n[0] = hit.normal_x; n[1] = hit.normal_y; n[2] = hit.normal_z;
		s[0] = 64'(hit.light_x) + 64'(hit.view_x);
		s[1] = 64'(hit.light_y) + 64'(hit.view_y);
		s[2] = 64'(hit.light_z) + 64'(hit.view_z);
		d  = 0;
		sq = 0;
		for (int k = 0; k < 3; k++) begin
			d  = d + n[k] * s[k];
			sq = sq + 64'(s[k] * s[k]);
		end
		h = 0;
		if (sq != 0 && d > 0) begin
			r = root64(sq << 20);
			h = (64'(d) << 10) / r;
			if (h > 16384) h = 16384;
		end
		f = spec_power(h);
		dif[0] = hit.diffuse_rgb[47:32];
		dif[1] = hit.diffuse_rgb[31:16];
		dif[2] = hit.diffuse_rgb[15:0];
		sp[0] = spec_r; sp[1] = spec_g; sp[2] = spec_b;
		for (int k = 0; k < 3; k++) begin
			v = dif[k] + ((sp[k] * f) >> 14);
			if (v > bps_pkg::OUT_MAX) v = bps_pkg::OUT_MAX;
			if (k == 0) res.red = v[16:0];
			else if (k == 1) res.green = v[16:0];
			else res.blue = v[16:0];
		end
		return res;
	endfunction

	assign pending = color_q.size();

	always @(posedge clk or negedge arst_n) begin
		rgb_t want;
		if (!arst_n) begin
			spec_r <= 0; spec_g <= 0; spec_b <= 0; shine <= 0;
			errors <= 0;
			colors_seen <= 0;
			color_q.delete();
		end else begin
			if (color.valid && color.ready) begin
				colors_seen <= colors_seen + 1;
				if (color_q.size() == 0) begin
					$display("%0t: color with no hit pending: %h %h %h", $time,
						color.out_red, color.out_green, color.out_blue);
					errors <= errors + 1;
				end else begin
					want = color_q.pop_front();
					if (want.red !== color.out_red || want.green !== color.out_green
						|| want.blue !== color.out_blue) begin
						$display("%0t: color mismatch: expected %h %h %h, got %h %h %h",
							$time, want.red, want.green, want.blue,
							color.out_red, color.out_green, color.out_blue);
						errors <= errors + 1;
					end
				end
			end
			if (hit.valid && hit.ready)
				color_q.push_back(shade_hit());
			if (cfg_we) begin
				case (cfg_index)
					bps_pkg::CFG_SPEC_RED:   spec_r <= cfg_data;
					bps_pkg::CFG_SPEC_GREEN: spec_g <= cfg_data;
					bps_pkg::CFG_SPEC_BLUE:  spec_b <= cfg_data;
					bps_pkg::CFG_SHININESS:  shine  <= cfg_data;
				endcase
			end
		end
	end

endmodule

### sim/tb_blinn_phong_shade_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Blinn-Phong shade unit testbench
// Drives hits with random gaps, stalls the color side, sweeps register
// settings between phases; the checker predicts and compares every color.
// ----------------------------------------------------------------------------
module tb_blinn_phong_shade_unit;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic [1:0]  cfg_index = bps_pkg::CFG_SPEC_RED;
	logic [15:0] cfg_data = 0;
	int          errors, pending, colors_seen;
	int          hits_sent = 0;
	bit          calm = 0;
	bit          hold_off = 0;

	bps_hit_if   hit ();
	bps_color_if color ();

	blinn_phong_shade_unit u_top (
		.clk, .arst_n, .hit(hit.sink), .color(color.source),
		.cfg_we, .cfg_index, .cfg_data
	);

	bps_shade_checker u_chk (
		.clk, .arst_n, .hit, .color, .cfg_we, .cfg_index, .cfg_data,
		.errors, .pending, .colors_seen
	);

	always #10 clk = ~clk;

	initial begin
		#20ms;
		$display("tb_blinn_phong_shade_unit: done, errors");
		$finish;
	end

	// receiver: random stall bursts, one long hold-off on request
	initial begin
		int n;
		color.ready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				color.ready <= 0;
				repeat (150) @(negedge clk);
				hold_off = 0;
			end
			if (!calm && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 10);
				color.ready <= 0;
				repeat (n - 1) @(negedge clk);
			end else begin
				color.ready <= 1;
			end
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_we    <= 1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 0;
	endtask

	task automatic set_regs(input logic [15:0] r, g, b, sh);
		write_reg(bps_pkg::CFG_SPEC_RED, r);
		write_reg(bps_pkg::CFG_SPEC_GREEN, g);
		write_reg(bps_pkg::CFG_SPEC_BLUE, b);
		write_reg(bps_pkg::CFG_SHININESS, sh);
	endtask

	// drop the offer and wait until every hit has come out
	task automatic drain();
		hit.valid <= 0;
		while (pending != 0)
			@(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	// offer one hit at the falling edge and hold it until transferred
	task automatic send_hit(input logic [15:0] v [9], input logic [47:0] dif,
			input logic ff);
		int gap;
		if (!calm && $urandom_range(0, 6) == 0) begin
			gap = $urandom_range(1, 10);
			hit.valid <= 0;
			repeat (gap) @(negedge clk);
		end
		hit.valid       <= 1;
		hit.normal_x    <= v[0]; hit.normal_y <= v[1]; hit.normal_z <= v[2];
		hit.light_x     <= v[3]; hit.light_y  <= v[4]; hit.light_z  <= v[5];
		hit.view_x      <= v[6]; hit.view_y   <= v[7]; hit.view_z   <= v[8];
		hit.diffuse_rgb <= dif;
		hit.front_face  <= ff;
		@(posedge clk);
		while (!hit.ready)
			@(posedge clk);
		hits_sent++;
		@(negedge clk);
	endtask

	// unit-ish vectors most of the time, raw noise otherwise
	task automatic random_hit();
		logic [15:0] v [9];
		logic [47:0] dif;
		for (int k = 0; k < 9; k++) begin
			if ($urandom_range(0, 3) == 0)
				v[k] = 16'($urandom);
			else
				v[k] = 16'($signed($urandom_range(0, 32768)) - 16384);
		end
		if ($urandom_range(0, 4) == 0) begin
			v[0] = v[3]; v[1] = v[4]; v[2] = v[5];
			v[6] = v[3]; v[7] = v[4]; v[8] = v[5];
		end
		dif = 48'({$urandom, $urandom});
		if ($urandom_range(0, 1)) dif = dif & 48'h3FFF_3FFF_3FFF;
		send_hit(v, dif, $urandom_range(0, 7) != 0);
	endtask

	initial begin
		logic [15:0] v [9];
		logic [15:0] sh [6];
		sh = '{16'd0, 16'd256, 16'h2000, 16'h0080, 16'hFFFF, 16'd1};
		hit.valid = 0;
		{hit.normal_x, hit.normal_y, hit.normal_z} = '0;
		{hit.light_x, hit.light_y, hit.light_z} = '0;
		{hit.view_x, hit.view_y, hit.view_z} = '0;
		hit.diffuse_rgb = 0;
		hit.front_face = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: extremes, zero sum, back face, aligned, opposite, 0^0
		set_regs(16'hFFFF, 16'h4000, 16'h0000, 16'h0000);
		v = '{default: 16'h0};
		send_hit(v, 48'h0, 1);
		send_hit(v, 48'hFFFF_FFFF_FFFF, 1);
		send_hit(v, 48'hFFFF_FFFF_FFFF, 0);
		drain();
		set_regs(16'hFFFF, 16'hFFFF, 16'h4000, 16'h2000);
		v = '{16'h4000, 0, 0, 16'h4000, 0, 0, 16'h4000, 0, 0};
		send_hit(v, 48'h0, 1);
		send_hit(v, 48'hFFFF_FFFF_FFFF, 1);
		v = '{16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF,
			16'h7FFF, 16'h7FFF, 16'h7FFF};
		send_hit(v, 48'h1234_5678_9ABC, 1);
		v = '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000,
			16'h8000, 16'h8000, 16'h8000};
		send_hit(v, 48'h0, 1);
		v = '{16'h4000, 0, 0, 16'hC000, 0, 0, 16'hC000, 0, 0};
		send_hit(v, 48'h0, 1);
		v = '{16'h4000, 0, 0, 16'h4000, 0, 0, 16'hC000, 0, 0};
		send_hit(v, 48'h0, 1);
		v = '{16'h2D41, 16'h2D41, 0, 0, 16'h4000, 0, 16'h4000, 0, 0};
		send_hit(v, 48'h0, 1);
		v = '{16'h0001, 0, 0, 16'h4000, 16'h3000, 0, 16'h4000, 16'h3000, 0};
		send_hit(v, 48'h0, 1);
		drain();

		// random phases over several settings
		for (int ph = 0; ph < 6; ph++) begin
			set_regs(16'($urandom), 16'($urandom), 16'($urandom), sh[ph]);
			if (ph == 2) set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0100);
			if (ph == 3) hold_off = 1;
			if (ph == 5) calm = 1;
			for (int i = 0; i < 270; i++)
				random_hit();
			hit.valid <= 0;
			drain();
		end

		while (pending != 0)
			@(negedge clk);
		repeat (60) @(negedge clk);
		$display("Shaded %0d hits, %0d colors checked, over six register settings",
			hits_sent, colors_seen);
		$display("including zero and full shininess, back faces and a long output stall.");
		if (errors == 0)
			$display("tb_blinn_phong_shade_unit: done, clean");
		else
			$display("tb_blinn_phong_shade_unit: done, errors");
		$finish;
	end

endmodule
